/* sv/ssd_pkg.sv */
// Shared constants, types and the segment glyph table for the scan driver.
// No dependencies; ssd_prep, ssd_core and the top level use it by scoped names.
`default_nettype none
package ssd_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int POS_W      = $clog2(NUM_DIGITS);

  localparam logic [2:0] OP_DECIMAL = 3'd0;
  localparam logic [2:0] OP_HEX     = 3'd1;
  localparam logic [2:0] OP_TIME    = 3'd2;
  localparam logic [2:0] OP_MASK    = 3'd3;
  localparam logic [2:0] OP_BLINK   = 3'd4;
  localparam logic [2:0] OP_SCAN    = 3'd5;

  localparam logic [15:0] DECIMAL_MAX = 16'd9999;
  localparam logic [6:0]  SEG_DASH    = 7'h40;

  // reciprocal constants, exact over the ranges used
  localparam logic [15:0] RECIP_10    = 16'd52429;  // >> 19
  localparam logic [15:0] RECIP_100   = 16'd5243;   // >> 19
  localparam logic [15:0] RECIP_1000  = 16'd16778;  // >> 24
  localparam logic [7:0]  RECIP_10_S  = 8'd205;     // >> 11, 7-bit inputs

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] value;
    logic        over_max;
    logic [12:0] q10;
    logic [9:0]  q100;
    logic [7:0]  q1000;
    logic [6:0]  hour;
    logic [3:0]  hour_tens;
    logic [6:0]  minute;
    logic [3:0]  minute_tens;
    logic [3:0]  blink_bits;
  } stage_t;

  function automatic logic [6:0] glyph(input logic [3:0] nib);
    logic [6:0] g;
    case (nib)
      4'h0: g = 7'h3F;
      4'h1: g = 7'h06;
      4'h2: g = 7'h5B;
      4'h3: g = 7'h4F;
      4'h4: g = 7'h66;
      4'h5: g = 7'h6D;
      4'h6: g = 7'h7D;
      4'h7: g = 7'h07;
      4'h8: g = 7'h7F;
      4'h9: g = 7'h6F;
      4'hA: g = 7'h77;
      4'hB: g = 7'h7C;
      4'hC: g = 7'h39;
      4'hD: g = 7'h5E;
      4'hE: g = 7'h79;
      4'hF: g = 7'h71;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

  // low decimal digit of x, given q = x / 10
  function automatic logic [3:0] rem10(input logic [15:0] x, input logic [15:0] q);
    logic [15:0] r;
    r = x - {q[12:0], 3'b000} - {q[14:0], 1'b0};
    return r[3:0];
  endfunction

endpackage
`default_nettype wire

/* sv/ssd_if.sv */
// Valid/ready channel interfaces for the scan driver: item and result.
// Depends on nothing.
`default_nettype none
interface ssd_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] value;
  logic [6:0]  hour;
  logic [6:0]  minute;
  logic [3:0]  blink_bits;
  modport source (output valid, output opcode, output value, output hour,
                  output minute, output blink_bits, input ready);
  modport sink   (input valid, input opcode, input value, input hour,
                  input minute, input blink_bits, output ready);
endinterface

interface ssd_result_if;
  logic       valid;
  logic       ready;
  logic [6:0] segments;
  logic [3:0] commons;
  logic       blink_phase;
  modport source (output valid, output segments, output commons,
                  output blink_phase, input ready);
  modport sink   (input valid, input segments, input commons,
                  input blink_phase, output ready);
endinterface
`default_nettype wire

/* sv/ssd_prep.sv */
// Input register: captures one item and the constant-divisor quotients.
// Depends on ssd_pkg and ssd_if.
`default_nettype none
module ssd_prep (
  input  wire logic     clk,
  input  wire logic     rst,
  ssd_item_if.sink      item,
  input  wire logic     take,
  output logic          stage_valid,
  output ssd_pkg::stage_t stage
);

  ssd_pkg::stage_t stage_next;
  logic [31:0] p10, p100, p1000;
  logic [14:0] ph, pm;
  logic        fire;

  assign item.ready = !stage_valid || take;
  assign fire       = item.valid && item.ready;

  always_comb begin
    p10   = {16'd0, item.value} * {16'd0, ssd_pkg::RECIP_10};
    p100  = {16'd0, item.value} * {16'd0, ssd_pkg::RECIP_100};
    p1000 = {16'd0, item.value} * {16'd0, ssd_pkg::RECIP_1000};
    ph    = {8'd0, item.hour} * {7'd0, ssd_pkg::RECIP_10_S};
    pm    = {8'd0, item.minute} * {7'd0, ssd_pkg::RECIP_10_S};
    stage_next.opcode      = item.opcode;
    stage_next.value       = item.value;
    stage_next.over_max    = item.value > ssd_pkg::DECIMAL_MAX;
    stage_next.q10         = p10[31:19];
    stage_next.q100        = p100[28:19];
    stage_next.q1000       = p1000[31:24];
    stage_next.hour        = item.hour;
    stage_next.hour_tens   = ph[14:11];
    stage_next.minute      = item.minute;
    stage_next.minute_tens = pm[14:11];
    stage_next.blink_bits  = item.blink_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (fire) begin
      stage_valid <= 1'b1;
    end else if (take) begin
      stage_valid <= 1'b0;
    end
    if (fire) begin
      stage <= stage_next;
    end
  end

endmodule
`default_nettype wire

/* sv/ssd_core.sv */
// Display state, opcode execution and the result register.
// Depends on ssd_pkg and ssd_if.
`default_nettype none
module ssd_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            stage_valid,
  input  wire ssd_pkg::stage_t stage,
  output logic                 take,
  ssd_result_if.source         result
);

  logic [6:0] pattern      [ssd_pkg::NUM_DIGITS];
  logic [6:0] pattern_next [ssd_pkg::NUM_DIGITS];
  logic [ssd_pkg::POS_W-1:0]      pos, pos_next, pos_inc;
  logic [ssd_pkg::NUM_DIGITS-1:0] blink, blink_next;
  logic                           phase, phase_next;
  logic [6:0]                     seg, seg_next;
  logic [ssd_pkg::NUM_DIGITS-1:0] com, com_next;
  logic                           out_valid;
  logic [3:0] d0, d1, d2, hr, mr;

  assign take = stage_valid && (!out_valid || result.ready);

  assign result.valid       = out_valid;
  assign result.segments    = seg;
  assign result.commons     = com;
  assign result.blink_phase = phase;

  always_comb begin
    d0 = ssd_pkg::rem10(stage.value, {3'd0, stage.q10});
    d1 = ssd_pkg::rem10({3'd0, stage.q10}, {6'd0, stage.q100});
    d2 = ssd_pkg::rem10({6'd0, stage.q100}, {8'd0, stage.q1000});
    hr = ssd_pkg::rem10({9'd0, stage.hour}, {12'd0, stage.hour_tens});
    mr = ssd_pkg::rem10({9'd0, stage.minute}, {12'd0, stage.minute_tens});
    pos_inc = pos + 1'b1;

    pattern_next = pattern;
    pos_next     = pos;
    blink_next   = blink;
    phase_next   = phase;
    seg_next     = seg;
    com_next     = com;

    case (stage.opcode)
      ssd_pkg::OP_DECIMAL: begin
        if (stage.over_max) begin
          for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++) begin
            pattern_next[i] = ssd_pkg::SEG_DASH;
          end
        end else begin
          pattern_next[3] = ssd_pkg::glyph(d0);
          pattern_next[2] = ssd_pkg::glyph(d1);
          pattern_next[1] = ssd_pkg::glyph(d2);
          pattern_next[0] = ssd_pkg::glyph(stage.q1000[3:0]);
        end
      end
      ssd_pkg::OP_HEX: begin
        pattern_next[3] = ssd_pkg::glyph(stage.value[3:0]);
        pattern_next[2] = ssd_pkg::glyph(stage.value[7:4]);
        pattern_next[1] = ssd_pkg::glyph(stage.value[11:8]);
        pattern_next[0] = ssd_pkg::glyph(stage.value[15:12]);
      end
      ssd_pkg::OP_TIME: begin
        pattern_next[0] = ssd_pkg::glyph(stage.hour_tens);
        pattern_next[1] = ssd_pkg::glyph(hr);
        pattern_next[2] = ssd_pkg::glyph(stage.minute_tens);
        pattern_next[3] = ssd_pkg::glyph(mr);
      end
      ssd_pkg::OP_MASK: begin
        if (blink != stage.blink_bits) begin
          phase_next = 1'b0;
        end
        blink_next = stage.blink_bits;
      end
      ssd_pkg::OP_BLINK: begin
        phase_next = !phase;
      end
      ssd_pkg::OP_SCAN: begin
        pos_next = pos_inc;
        if (blink[pos_inc] && phase) begin
          seg_next = 7'd0;
          com_next = '0;
        end else begin
          seg_next = pattern[pos_inc];
          com_next = {{(ssd_pkg::NUM_DIGITS-1){1'b0}}, 1'b1} << pos_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ssd_pkg::NUM_DIGITS; i++) begin
        pattern[i] <= 7'd0;
      end
      pos       <= '0;
      blink     <= '0;
      phase     <= 1'b0;
      seg       <= 7'd0;
      com       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        pattern   <= pattern_next;
        pos       <= pos_next;
        blink     <= blink_next;
        phase     <= phase_next;
        seg       <= seg_next;
        com       <= com_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/seven_segment_scan_driver_top.sv */
// Four-digit multiplexed seven-segment scan driver, top level.
// Depends on ssd_pkg, ssd_if, ssd_prep and ssd_core.
//
// One item is accepted per cycle while results are taken; each gives a result.
// The input register holds the item with its divide-by-ten, -hundred and
// -thousand quotients (reciprocal multiplies); once the result register is free
// or being taken, the core finishes the digit remainders, updates the display
// state and loads the result register, which holds a result the sink has not
// yet taken while the next item waits in the input register. Results carry the
// segment and common pin drive as it stands after the item, plus the blink phase.
`default_nettype none
module seven_segment_scan_driver_top (
  input  wire logic    clk,
  input  wire logic    rst,
  ssd_item_if.sink     item,
  ssd_result_if.source result
);

  ssd_pkg::stage_t stage;
  logic            stage_valid;
  logic            take;

  ssd_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .take        (take),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  ssd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage       (stage),
    .take        (take),
    .result      (result)
  );

endmodule
`default_nettype wire
